[design/timed_command_queue_unit_assert.svh]
// assertion macros used by timed_command_queue_unit
`ifndef TIMED_COMMAND_QUEUE_UNIT_ASSERT_SVH
`define TIMED_COMMAND_QUEUE_UNIT_ASSERT_SVH

// checked on every rising edge, disabled while reset is high
`define TCQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define TCQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[design/tcq_pkg.sv]
// ----------------------------------------------------------------------------
// tcq_pkg
// shared types, codes and constants of the timed command queue
// ----------------------------------------------------------------------------
package tcq_pkg;

   localparam int QUEUE_SLOTS_DEF   = 64;
   localparam int VOICE_COUNT_DEF   = 4;
   localparam int CHANNEL_COUNT_DEF = 16;

   localparam logic [15:0] SLACK_RESET    = 16'd200;
   localparam logic [7:0]  CC_BASE        = 8'hB0;
   localparam logic [7:0]  ALL_NOTES_OFF  = 8'd123;
   localparam logic [7:0]  SERIAL_MAX_LEN = 8'd3;
   localparam logic [5:0]  MAX_FIRES      = 6'd63;

   // register byte address of the slack register
   localparam logic [1:0] ADDR_SLACK = 2'd0;

   localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [1:0] KIND_SERIAL   = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_TICK  = 3'd1,
      OP_PURGE = 3'd2,
      OP_CLEAR = 3'd3,
      OP_STATS = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_DROPPED  = 3'd1,
      ST_FIRED    = 3'd2,
      ST_SILENCE  = 3'd3,
      ST_NOTHING  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TICK_RD,
      S_TICK_EV,
      S_PURGE_RD,
      S_PURGE_EV,
      S_SILENCE
   } state_type;

   typedef struct packed {
      logic [63:0] due;
      logic [1:0]  kind;
      logic [7:0]  source;
      logic [47:0] payload;
   } entry_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  kind;
      logic [7:0]  source;
      logic [47:0] payload;
      logic [31:0] lateness;
      logic        malformed;
      logic [5:0]  fill_level;
      logic        last;
      logic [31:0] fired_total;
      logic [31:0] dropped_total;
      logic [31:0] worst_lateness;
      logic [5:0]  peak_fill;
   } result_type;

endpackage

[design/tcq_ram.sv]
// ----------------------------------------------------------------------------
// tcq_ram
// ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module tcq_ram #(
   parameter int DEPTH = tcq_pkg::QUEUE_SLOTS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tcq_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output tcq_pkg::entry_type  rd_data
);
   import tcq_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[design/tcq_rsp_reg.sv]
// ----------------------------------------------------------------------------
// tcq_rsp_reg
// output register of the result channel
// ----------------------------------------------------------------------------
module tcq_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tcq_pkg::result_type load_data,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tcq_pkg::result_type rsp_data
);
   import tcq_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign space     = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

[design/timed_command_queue_unit.sv]
// ----------------------------------------------------------------------------
// timed_command_queue_unit
// ring of time-stamped commands with tick firing and per-source purge
// ----------------------------------------------------------------------------
// push, clear, stats reset and unknown ops: S_EXEC hands the result to the output reg once free
// tick: per fired command, S_TICK_RD reads the one ring read port and S_TICK_EV judges the entry
// purge: read, compact write per entry; then one silence result per cycle while output has space
// one item in work at a time; a new transfer is taken once the last result is in the output reg
// reset (synchronous, active high): ring empty, statistics zero, slack 200; ring contents
// are not cleared, only entries between head and tail are ever read
module timed_command_queue_unit #(
   parameter int QUEUE_SLOTS   = tcq_pkg::QUEUE_SLOTS_DEF,
   parameter int VOICE_COUNT   = tcq_pkg::VOICE_COUNT_DEF,
   parameter int CHANNEL_COUNT = tcq_pkg::CHANNEL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [63:0] req_due_time,
   input  logic [1:0]  req_cmd_kind_in,
   input  logic [7:0]  req_source_id,
   input  logic [47:0] req_payload_in,
   input  logic [63:0] req_now_time,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_cmd_kind_out,
   output logic [7:0]  rsp_source_out,
   output logic [47:0] rsp_payload_out,
   output logic [31:0] rsp_lateness,
   output logic        rsp_malformed,
   output logic [5:0]  rsp_fill_level,
   output logic        rsp_last,
   output logic [31:0] rsp_fired_total,
   output logic [31:0] rsp_dropped_total,
   output logic [31:0] rsp_worst_lateness,
   output logic [5:0]  rsp_peak_fill,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tcq_pkg::*;
   `include "timed_command_queue_unit_assert.svh"

   localparam int IW = $clog2(QUEUE_SLOTS);

   // ring index step with wrap at the slot count
   function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
      return (i == IW'(QUEUE_SLOTS - 1)) ? '0 : i + 1'b1;
   endfunction

   // held entries, saturated to the 6-bit field
   function automatic logic [5:0] fill_sat(input logic [IW-1:0] h, input logic [IW-1:0] t);
      logic [IW:0] f;
      f = {1'b0, t} - {1'b0, h} + ((t < h) ? (IW+1)'(QUEUE_SLOTS) : '0);
      return (32'(f) > 32'd63) ? 6'd63 : 6'(f);
   endfunction

   // control and state registers
   state_type   state_ff, state_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, rd_ff, rd_in, wr_ff, wr_in;
   logic [31:0] fired_ff, fired_in, dropped_ff, dropped_in, max_late_ff, max_late_in;
   logic [5:0]  max_fill_ff, max_fill_in;
   logic [15:0] slack_ff;
   logic [5:0]  fire_cnt_ff, fire_cnt_in;
   logic        pend_v_ff, pend_v_in;
   logic        had_note_ff, had_note_in, had_ser_ff, had_ser_in;
   logic        chan_ph_ff, chan_ph_in;
   logic [4:0]  sil_ff, sil_in;

   // payload registers of the item in work
   logic [2:0]  op_ff;
   logic [63:0] due_ff, now_ff;
   logic [64:0] nps_ff;
   logic [1:0]  kind_ff;
   logic [7:0]  src_ff;
   logic [47:0] payload_ff;
   result_type  pend_ff, pend_in;

   // ring port and result handoff
   logic        wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   entry_type   wr_data, rd_data;
   logic        emit_v, space;
   result_type  emit_res, rsp_data, base_res;

   // tick evaluation of the head entry
   logic        fires, tk_more, malf, full;
   logic [63:0] late64;
   logic [31:0] late;

   logic        req_xfer;
   assign req_xfer  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // configuration: single register at address 0
   assign pready = 1'b1;
   assign prdata = {16'b0, slack_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         slack_ff <= SLACK_RESET;
      end else if (psel && penable && pwrite && (paddr == ADDR_SLACK)) begin
         slack_ff <= pwdata[15:0];
      end
   end

   tcq_ram #(.DEPTH(QUEUE_SLOTS), .AW(IW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tcq_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (emit_v),
      .load_data (emit_res),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_cmd_kind_out   = rsp_data.kind;
   assign rsp_source_out     = rsp_data.source;
   assign rsp_payload_out    = rsp_data.payload;
   assign rsp_lateness       = rsp_data.lateness;
   assign rsp_malformed      = rsp_data.malformed;
   assign rsp_fill_level     = rsp_data.fill_level;
   assign rsp_last           = rsp_data.last;
   assign rsp_fired_total    = rsp_data.fired_total;
   assign rsp_dropped_total  = rsp_data.dropped_total;
   assign rsp_worst_lateness = rsp_data.worst_lateness;
   assign rsp_peak_fill      = rsp_data.peak_fill;

   // head entry due when due <= now + slack, sum kept at 65 bits
   assign fires   = ({1'b0, rd_data.due} <= nps_ff);
   assign tk_more = (head_ff != tail_ff) && (fire_cnt_ff != MAX_FIRES) && fires;
   assign late64  = now_ff - rd_data.due;
   assign late    = (now_ff > rd_data.due) ? ((|late64[63:32]) ? '1 : late64[31:0]) : '0;
   assign malf    = (rd_data.kind == KIND_UNKNOWN) ||
                    ((rd_data.kind == KIND_SERIAL) &&
                     ((rd_data.payload[7:0] == 8'd0) ||
                      (rd_data.payload[7:0] > SERIAL_MAX_LEN)));
   assign full    = (nxt(tail_ff) == head_ff);

   // result with no command and the present statistics
   always_comb begin
      base_res                = '0;
      base_res.status         = ST_NOTHING;
      base_res.fill_level     = fill_sat(head_ff, tail_ff);
      base_res.fired_total    = fired_ff;
      base_res.dropped_total  = dropped_ff;
      base_res.worst_lateness = max_late_ff;
      base_res.peak_fill      = max_fill_ff;
      base_res.last           = 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_TICK:  state_in = S_TICK_RD;
               OP_PURGE: state_in = S_PURGE_RD;
               default: begin
                  if (space) begin
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_TICK_RD: state_in = S_TICK_EV;
         S_TICK_EV: begin
            if (tk_more) begin
               if (!pend_v_ff || space) begin
                  state_in = S_TICK_RD;
               end
            end else if (space) begin
               state_in = S_IDLE;
            end
         end
         S_PURGE_RD: state_in = (rd_ff == tail_ff) ? S_SILENCE : S_PURGE_EV;
         S_PURGE_EV: state_in = S_PURGE_RD;
         S_SILENCE: begin
            if (space) begin
               if (!had_note_ff && !had_ser_ff) begin
                  state_in = S_IDLE;
               end else if (!chan_ph_ff) begin
                  if ((sil_ff == 5'(VOICE_COUNT - 1)) && !had_ser_ff) begin
                     state_in = S_IDLE;
                  end
               end else if (sil_ff == 5'(CHANNEL_COUNT - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      fired_in    = fired_ff;
      dropped_in  = dropped_ff;
      max_late_in = max_late_ff;
      max_fill_in = max_fill_ff;
      fire_cnt_in = fire_cnt_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      had_note_in = had_note_ff;
      had_ser_in  = had_ser_ff;
      chan_ph_in  = chan_ph_ff;
      sil_in      = sil_ff;
      wr_en       = 1'b0;
      wr_addr     = tail_ff;
      wr_data     = '{due: due_ff, kind: kind_ff, source: src_ff, payload: payload_ff};
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      emit_v      = 1'b0;
      emit_res    = base_res;

      unique case (state_ff)
         S_IDLE: ;
         S_EXEC: begin
            unique case (op_ff)
               OP_PUSH: begin
                  if (space) begin
                     emit_v = 1'b1;
                     if (full) begin
                        dropped_in             = dropped_ff + 1'b1;
                        emit_res.status        = ST_DROPPED;
                        emit_res.dropped_total = dropped_in;
                     end else begin
                        wr_en   = 1'b1;
                        tail_in = nxt(tail_ff);
                        if (fill_sat(head_ff, tail_in) > max_fill_ff) begin
                           max_fill_in = fill_sat(head_ff, tail_in);
                        end
                        emit_res.status     = ST_ACCEPTED;
                        emit_res.fill_level = fill_sat(head_ff, tail_in);
                        emit_res.peak_fill  = max_fill_in;
                     end
                  end
               end
               OP_TICK: begin
                  fire_cnt_in = '0;
                  pend_v_in   = 1'b0;
               end
               OP_PURGE: begin
                  rd_in       = head_ff;
                  wr_in       = head_ff;
                  had_note_in = 1'b0;
                  had_ser_in  = 1'b0;
               end
               OP_CLEAR: begin
                  if (space) begin
                     emit_v              = 1'b1;
                     head_in             = '0;
                     tail_in             = '0;
                     emit_res.fill_level = '0;
                  end
               end
               OP_STATS: begin
                  if (space) begin
                     emit_v                  = 1'b1;
                     fired_in                = '0;
                     dropped_in              = '0;
                     max_late_in             = '0;
                     max_fill_in             = '0;
                     emit_res.fired_total    = '0;
                     emit_res.dropped_total  = '0;
                     emit_res.worst_lateness = '0;
                     emit_res.peak_fill      = '0;
                  end
               end
               default: begin
                  emit_v = space;
               end
            endcase
         end
         S_TICK_RD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         S_TICK_EV: begin
            if (tk_more) begin
               // the previous fire goes out now, this one waits to learn if it is last
               if (!pend_v_ff || space) begin
                  emit_v        = pend_v_ff;
                  emit_res      = pend_ff;
                  emit_res.last = 1'b0;
                  head_in       = nxt(head_ff);
                  fired_in      = fired_ff + 1'b1;
                  fire_cnt_in   = fire_cnt_ff + 1'b1;
                  if (late > max_late_ff) begin
                     max_late_in = late;
                  end
                  pend_v_in              = 1'b1;
                  pend_in                = base_res;
                  pend_in.status         = ST_FIRED;
                  pend_in.kind           = rd_data.kind;
                  pend_in.source         = rd_data.source;
                  pend_in.payload        = rd_data.payload;
                  pend_in.lateness       = late;
                  pend_in.malformed      = malf;
                  pend_in.fill_level     = fill_sat(head_in, tail_ff);
                  pend_in.fired_total    = fired_in;
                  pend_in.worst_lateness = max_late_in;
               end
            end else if (space) begin
               emit_v = 1'b1;
               if (pend_v_ff) begin
                  emit_res      = pend_ff;
                  emit_res.last = 1'b1;
               end
               pend_v_in = 1'b0;
            end
         end
         S_PURGE_RD: begin
            if (rd_ff == tail_ff) begin
               tail_in    = wr_ff;
               chan_ph_in = !had_note_ff;
               sil_in     = '0;
            end else begin
               rd_en   = 1'b1;
               rd_addr = rd_ff;
            end
         end
         S_PURGE_EV: begin
            // survivors are copied down to the write pointer, order kept
            if (rd_data.source == src_ff) begin
               if (rd_data.kind == KIND_SERIAL) begin
                  had_ser_in = 1'b1;
               end else begin
                  had_note_in = 1'b1;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = wr_ff;
               wr_data = rd_data;
               wr_in   = nxt(wr_ff);
            end
            rd_in = nxt(rd_ff);
         end
         S_SILENCE: begin
            if (space) begin
               emit_v = 1'b1;
               if (had_note_ff || had_ser_ff) begin
                  emit_res.status = ST_SILENCE;
                  emit_res.source = src_ff;
                  if (!chan_ph_ff) begin
                     // voice note-off, payload byte 0 is the voice number
                     emit_res.kind    = KIND_NOTE_OFF;
                     emit_res.payload = 48'(sil_ff);
                     emit_res.last    = (sil_ff == 5'(VOICE_COUNT - 1)) && !had_ser_ff;
                     if (sil_ff == 5'(VOICE_COUNT - 1)) begin
                        chan_ph_in = 1'b1;
                        sil_in     = '0;
                     end else begin
                        sil_in = sil_ff + 1'b1;
                     end
                  end else begin
                     // all-notes-off control message per channel
                     emit_res.kind    = KIND_SERIAL;
                     emit_res.payload = {24'b0, ALL_NOTES_OFF,
                                         CC_BASE | {3'b0, sil_ff}, SERIAL_MAX_LEN};
                     emit_res.last    = (sil_ff == 5'(CHANNEL_COUNT - 1));
                     sil_in           = sil_ff + 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         rd_ff       <= '0;
         wr_ff       <= '0;
         fired_ff    <= '0;
         dropped_ff  <= '0;
         max_late_ff <= '0;
         max_fill_ff <= '0;
         fire_cnt_ff <= '0;
         pend_v_ff   <= 1'b0;
         had_note_ff <= 1'b0;
         had_ser_ff  <= 1'b0;
         chan_ph_ff  <= 1'b0;
         sil_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         rd_ff       <= rd_in;
         wr_ff       <= wr_in;
         fired_ff    <= fired_in;
         dropped_ff  <= dropped_in;
         max_late_ff <= max_late_in;
         max_fill_ff <= max_fill_in;
         fire_cnt_ff <= fire_cnt_in;
         pend_v_ff   <= pend_v_in;
         had_note_ff <= had_note_in;
         had_ser_ff  <= had_ser_in;
         chan_ph_ff  <= chan_ph_in;
         sil_ff      <= sil_in;
      end
   end

   // item and pending fire payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff      <= req_op;
         due_ff     <= req_due_time;
         now_ff     <= req_now_time;
         nps_ff     <= {1'b0, req_now_time} + 65'(slack_ff);
         kind_ff    <= req_cmd_kind_in;
         src_ff     <= req_source_id;
         payload_ff <= req_payload_in;
      end
      pend_ff <= pend_in;
   end

   // a result is handed over only when the output register can take it
   `TCQ_ASSERT(a_emit_space, emit_v |-> space, "result produced without output space")
   // no fire is left pending once the block is idle
   `TCQ_ASSERT(a_idle_no_pend, (state_ff == S_IDLE) |-> !pend_v_ff, "pending fire in idle")
   // an accepted item always starts its work in the next cycle
   `TCQ_ASSERT(a_xfer_exec, req_xfer |=> (state_ff == S_EXEC), "transfer did not start work")

endmodule

[tb/sv/timed_command_queue_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_command_queue_unit_tb
// self-checking bench: pushes, ticks, purges, clears, stats resets and spare ops go
// in over valid/ready, every transfer is run through a cycle-free ring model and the
// emitted results are compared field by field in order, across several slack settings
// ----------------------------------------------------------------------------
module timed_command_queue_unit_tb;
   import tcq_pkg::*;

   // codes with no package name
   localparam logic [1:0] KIND_NOTE_ON = 2'd0;
   localparam logic [2:0] OP_SPARE_5   = 3'd5;
   localparam logic [2:0] OP_SPARE_6   = 3'd6;
   localparam logic [2:0] OP_SPARE_7   = 3'd7;

   // ring model and the queue of results it predicts
   class ring_scoreboard;
      logic [63:0] due_mem [64];
      logic [1:0]  kind_mem [64];
      logic [7:0]  src_mem [64];
      logic [47:0] pay_mem [64];
      logic [5:0]  head, tail;
      logic [31:0] fired, dropped, worst;
      logic [5:0]  peak;
      logic [15:0] slack;
      result_type  expected [$];
      int          errors;

      function new();
         head = 0; tail = 0; fired = 0; dropped = 0; worst = 0; peak = 0;
         slack = SLACK_RESET; errors = 0;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function void add_result(logic [2:0] st, logic [1:0] k, logic [7:0] s,
                               logic [47:0] p, logic [31:0] late, logic malf);
         result_type r;
         r.status = st; r.kind = k; r.source = s; r.payload = p;
         r.lateness = late; r.malformed = malf; r.fill_level = tail - head;
         r.last = 1'b0; r.fired_total = fired; r.dropped_total = dropped;
         r.worst_lateness = worst; r.peak_fill = peak;
         expected.push_back(r);
      endfunction

      // work out every result of one accepted transfer
      function void note_item(logic [2:0] op, logic [63:0] due, logic [1:0] k,
                              logic [7:0] s, logic [47:0] p, logic [63:0] now);
         int n, v;
         logic [5:0] rd, wr;
         logic [63:0] d, late64;
         logic [31:0] late;
         logic malf, had_note, had_ser;
         n = 0;
         case (op)
            OP_PUSH: begin
               if (tail + 6'd1 == head) begin
                  dropped++;
                  add_result(ST_DROPPED, 0, 0, 0, 0, 0);
               end else begin
                  due_mem[tail] = due; kind_mem[tail] = k;
                  src_mem[tail] = s; pay_mem[tail] = p;
                  tail++;
                  if (tail - head > peak) peak = tail - head;
                  add_result(ST_ACCEPTED, 0, 0, 0, 0, 0);
               end
               n = 1;
            end
            OP_TICK: begin
               while (n < MAX_FIRES && head != tail) begin
                  d = due_mem[head];
                  // slack window checked without overflow of now + slack
                  if (d > now && d - now > {48'd0, slack}) break;
                  late64 = (now > d) ? now - d : 64'd0;
                  late = (late64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : late64[31:0];
                  malf = kind_mem[head] == KIND_UNKNOWN ||
                         (kind_mem[head] == KIND_SERIAL &&
                          (pay_mem[head][7:0] == 0 || pay_mem[head][7:0] > SERIAL_MAX_LEN));
                  v = head;
                  head++;
                  fired++;
                  if (late > worst) worst = late;
                  add_result(ST_FIRED, kind_mem[v], src_mem[v], pay_mem[v], late, malf);
                  n++;
               end
            end
            OP_PURGE: begin
               had_note = 0; had_ser = 0; rd = head; wr = head;
               while (rd != tail) begin
                  if (src_mem[rd] == s) begin
                     if (kind_mem[rd] == KIND_SERIAL) had_ser = 1;
                     else had_note = 1;
                  end else begin
                     due_mem[wr] = due_mem[rd]; kind_mem[wr] = kind_mem[rd];
                     src_mem[wr] = src_mem[rd]; pay_mem[wr] = pay_mem[rd];
                     wr++;
                  end
                  rd++;
               end
               tail = wr;
               if (had_note)
                  for (v = 0; v < VOICE_COUNT_DEF; v++) begin
                     add_result(ST_SILENCE, KIND_NOTE_OFF, s, 48'(v), 0, 0);
                     n++;
                  end
               if (had_ser)
                  for (v = 0; v < CHANNEL_COUNT_DEF; v++) begin
                     add_result(ST_SILENCE, KIND_SERIAL, s,
                                {24'd0, ALL_NOTES_OFF, CC_BASE | 8'(v), SERIAL_MAX_LEN},
                                0, 0);
                     n++;
                  end
            end
            OP_CLEAR: begin
               head = 0; tail = 0;
            end
            OP_STATS: begin
               fired = 0; dropped = 0; worst = 0; peak = 0;
            end
            default: ;
         endcase
         if (n == 0) add_result(ST_NOTHING, 0, 0, 0, 0, 0);
         expected[$].last = 1'b1;
      endfunction

      function void diff(string name, logic [63:0] e, logic [63:0] a);
         if (e !== a) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(result_type a);
         result_type e;
         if (expected.size() == 0) begin
            $display("%0t unexpected result: status %0d", $time, a.status);
            errors++;
            return;
         end
         e = expected.pop_front();
         diff("status", e.status, a.status);
         diff("cmd_kind", e.kind, a.kind);
         diff("source", e.source, a.source);
         diff("payload", e.payload, a.payload);
         diff("lateness", e.lateness, a.lateness);
         diff("malformed", e.malformed, a.malformed);
         diff("fill_level", e.fill_level, a.fill_level);
         diff("last", e.last, a.last);
         diff("fired_total", e.fired_total, a.fired_total);
         diff("dropped_total", e.dropped_total, a.dropped_total);
         diff("worst_lateness", e.worst_lateness, a.worst_lateness);
         diff("peak_fill", e.peak_fill, a.peak_fill);
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_op = 0;
   logic [63:0] req_due_time = 0;
   logic [1:0]  req_cmd_kind_in = 0;
   logic [7:0]  req_source_id = 0;
   logic [47:0] req_payload_in = 0;
   logic [63:0] req_now_time = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_cmd_kind_out;
   logic [7:0]  rsp_source_out;
   logic [47:0] rsp_payload_out;
   logic [31:0] rsp_lateness;
   logic        rsp_malformed;
   logic [5:0]  rsp_fill_level;
   logic        rsp_last;
   logic [31:0] rsp_fired_total;
   logic [31:0] rsp_dropped_total;
   logic [31:0] rsp_worst_lateness;
   logic [5:0]  rsp_peak_fill;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [1:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   ring_scoreboard sb = new();

   // no_idle turns off gaps on both sides; hold_request asks for one long stall
   bit          no_idle = 0;
   bit          hold_request = 0;
   logic [63:0] clk_us = 64'd1000;

   timed_command_queue_unit dut (.*);

   always #1 clock = ~clock;

   // generous limit, far beyond the slowest legal run
   initial begin
      #8000000;
      $display("FAILED: results differ");
      $finish;
   end

   // result side: every transfer goes to the scoreboard
   always @(posedge clock) begin
      result_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         a.status = rsp_status; a.kind = rsp_cmd_kind_out; a.source = rsp_source_out;
         a.payload = rsp_payload_out; a.lateness = rsp_lateness;
         a.malformed = rsp_malformed; a.fill_level = rsp_fill_level; a.last = rsp_last;
         a.fired_total = rsp_fired_total; a.dropped_total = rsp_dropped_total;
         a.worst_lateness = rsp_worst_lateness; a.peak_fill = rsp_peak_fill;
         sb.check_result(a);
      end
   end

   // mostly no gap or a short one, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random stalls, plus one long hold-off when asked
   initial begin
      int run;
      run = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            run = 0;
         end
         if (run == 0) begin
            if (no_idle || $urandom_range(1)) begin
               rsp_ready <= 1'b1;
               run = $urandom_range(1, 20);
            end else begin
               rsp_ready <= 1'b0;
               run = pick_gap() + 1;
            end
         end
         run--;
      end
   end

   // one transfer on the input channel, valid held until accepted
   task automatic send(logic [2:0] op, logic [63:0] due, logic [1:0] k,
                       logic [7:0] s, logic [47:0] p, logic [63:0] now);
      int gap;
      req_valid <= 1'b1;
      req_op <= op; req_due_time <= due; req_cmd_kind_in <= k;
      req_source_id <= s; req_payload_in <= p; req_now_time <= now;
      do @(posedge clock); while (!req_ready);
      sb.note_item(op, due, k, s, p, now);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // lower valid and let every expected result come out
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write the slack register, then read it back
   task automatic set_slack(logic [15:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_SLACK; pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      sb.slack = value;
      @(posedge clock);
      psel <= 1;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      if (prdata !== {16'd0, value}) begin
         $display("%0t mismatch slack readback: expected %0h actual %0h",
                  $time, value, prdata);
         sb.errors++;
      end
      psel <= 0; penable <= 0;
   endtask

   // random traffic around a moving clock; sources kept few so purges hit
   task automatic run_random(int count);
      int r;
      logic [63:0] due, now;
      logic [47:0] p;
      logic [7:0] s;
      repeat (count) begin
         r = $urandom_range(99);
         s = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
         p = 48'({$urandom, $urandom});
         if ($urandom_range(1)) p[7:0] = 8'($urandom_range(0, 5));
         if (r < 55) begin
            due = clk_us + 64'($urandom_range(0, 3000)) - 64'd1000;
            if ($urandom_range(19) == 0) due = {$urandom, $urandom};
            send(OP_PUSH, due, 2'($urandom), s, p, {$urandom, $urandom});
         end else if (r < 80) begin
            clk_us += 64'($urandom_range(0, 1500));
            now = ($urandom_range(19) == 0) ? {$urandom, $urandom} : clk_us;
            send(OP_TICK, {$urandom, $urandom}, 2'($urandom), s, p, now);
         end else if (r < 90)
            send(OP_PURGE, {$urandom, $urandom}, 2'($urandom), s, p, {$urandom, $urandom});
         else if (r < 94)
            send(OP_CLEAR, 0, 0, s, p, 0);
         else if (r < 97)
            send(OP_STATS, 0, 0, s, p, 0);
         else
            send(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)), 0, 0, s, p, 0);
      end
   endtask

   initial begin
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part with the reset slack
      send(OP_TICK, 0, 0, 0, 0, 0);                                   // empty tick
      send(OP_PURGE, 0, 0, 8'd5, 0, 0);                               // purge, nothing held
      send(OP_PUSH, 0, KIND_NOTE_ON, 0, 0, 0);
      send(OP_PUSH, '1, KIND_UNKNOWN, 8'hFF, '1, '1);
      send(OP_PUSH, 64'd100, KIND_SERIAL, 8'd7, 48'h0, 0);            // serial length 0
      send(OP_PUSH, 64'd150, KIND_SERIAL, 8'd7, 48'h3, 0);
      send(OP_PUSH, 64'd300, KIND_SERIAL, 8'd7, 48'h4, 0);            // serial too long
      send(OP_PUSH, 64'd2000, KIND_NOTE_OFF, 8'd9, 48'h1234, 0);
      send(OP_TICK, 0, 0, 0, 0, 64'd100);                             // blocked behind far entry
      send(OP_PURGE, 0, 0, 8'hFF, 0, 0);                              // unknown kind -> voice offs
      send(OP_TICK, 0, 0, 0, 0, 64'h1_0000_0100);                     // saturated lateness
      send(OP_PUSH, 64'd500, KIND_SERIAL, 8'd3, 48'h2, 0);
      send(OP_PUSH, 64'd501, KIND_NOTE_ON, 8'd3, 48'h40, 0);
      send(OP_PURGE, 0, 0, 8'd3, 0, 0);                               // voice and serial silence
      send(OP_PUSH, 64'd1000, KIND_NOTE_ON, 8'd1, 48'h1, 0);
      send(OP_TICK, 0, 0, 0, 0, 64'd800);                             // exactly at slack edge
      send(OP_PUSH, 64'd1201, KIND_NOTE_ON, 8'd1, 48'h2, 0);
      send(OP_TICK, 0, 0, 0, 0, 64'd1000);                            // one past slack
      send(OP_STATS, 0, 0, 0, 0, 0);
      send(OP_CLEAR, 0, 0, 0, 0, 0);
      send(OP_SPARE_5, 0, 0, 0, 0, 0);
      send(OP_SPARE_6, 0, 0, 0, 0, 0);
      send(OP_SPARE_7, 0, 0, 0, 0, 0);
      send(OP_PUSH, '1, KIND_NOTE_OFF, 8'd2, 0, 0);
      send(OP_TICK, 0, 0, 0, 0, '1);
      drain();

      // zero slack, no idling anywhere
      no_idle = 1;
      set_slack(16'd0);
      run_random(90);
      drain();
      no_idle = 0;

      // widest slack, ring flooded past full while the receiver holds off
      set_slack(16'hFFFF);
      run_random(60);
      send(OP_CLEAR, 0, 0, 0, 0, 0);
      hold_request = 1;
      for (i = 0; i < 68; i++)
         send(OP_PUSH, {$urandom, $urandom}, 2'($urandom), 8'($urandom_range(0, 3)),
              48'({$urandom, $urandom}), 0);
      send(OP_TICK, 0, 0, 0, 0, '1);                                  // longest tick
      run_random(40);
      drain();

      set_slack(16'($urandom));
      run_random(100);
      drain();

      set_slack(SLACK_RESET);
      run_random(40);
      drain();
      repeat (20) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/tcq_pkg.sv
design/tcq_ram.sv
design/tcq_rsp_reg.sv
design/timed_command_queue_unit.sv
tb/sv/timed_command_queue_unit_tb.sv
